// ===== hdl/uv_coordinate_transform_assert.svh =====
// Assertion macros used by the top level of the coordinate transform.
`ifndef UV_COORDINATE_TRANSFORM_ASSERT_SVH
`define UV_COORDINATE_TRANSFORM_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define UVCT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uvct check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define UVCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uvct check failed");

`endif

// ===== hdl/uvct_pkg.sv =====
// Shared constants, types and helper functions of the coordinate transform.
package uvct_pkg;

    localparam int WORD_BITS_DEF     = 32;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int TRIG_FRAC    = 30;
    localparam int TRIG_BITS    = 34;
    localparam int ANG_BITS     = 34;
    localparam int ATAN_ENTRIES = 30;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [31:0] GAIN_Q30 = 32'h26DD3B6A;

    localparam logic [31:0] ATAN_TURN [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_INVERT_S = 2'd0,
        CFG_INVERT_T = 2'd1
    } cfg_reg_t;

    // Sine and cosine of one item as they leave the CORDIC.
    typedef struct packed {
        logic                        vld;
        logic                        nz;
        logic signed [TRIG_BITS-1:0] cs;
        logic signed [TRIG_BITS-1:0] sn;
    } trig_t;

    // Multiplicative inverse of 45 modulo 2^32, by Newton iteration.
    function automatic logic [31:0] inv45();
        logic [63:0] x;
        x = 64'd45;
        for (int k = 0; k < 5; k++) begin
            x = x * (64'd2 - 64'd45 * x);
        end
        return x[31:0];
    endfunction

    localparam logic [31:0] INV45 = inv45();

    // Since 2^12 is 1 modulo 45, summing 12-bit digits keeps the residue.
    function automatic logic [14:0] mod45_fold(input logic [63:0] v);
        logic [71:0] p;
        logic [14:0] sum;
        p   = {8'd0, v};
        sum = '0;
        for (int k = 0; k < 6; k++) begin
            sum = sum + 15'(p[k*12 +: 12]);
        end
        return sum;
    endfunction

    // Residue modulo 45 of a folded digit sum, by a reciprocal multiply.
    function automatic logic [5:0] mod45_finish(input logic [14:0] x);
        logic [12:0] x2;
        logic [29:0] prod;
        logic [12:0] q;
        x2   = 13'(x[11:0]) + 13'(x[14:12]);
        prod = 30'(x2) * 30'd2913;
        q    = 13'(prod >> 17);
        return 6'(x2 - 13'(q * 13'd45));
    endfunction

endpackage

// ===== hdl/uvct_if.sv =====
// Channel interfaces: point items, result items and configuration writes.
interface uvct_pt_if #(parameter int W = uvct_pkg::WORD_BITS_DEF);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] coord_s;
    logic signed [W-1:0] coord_t;
    logic signed [W-1:0] radius_in;
    logic signed [W-1:0] scale_s;
    logic signed [W-1:0] scale_t;
    logic signed [W-1:0] offset_s;
    logic signed [W-1:0] offset_t;
    logic signed [W-1:0] angle_deg;
    modport source (output valid, coord_s, coord_t, radius_in, scale_s, scale_t,
                    offset_s, offset_t, angle_deg, input ready);
    modport sink (input valid, coord_s, coord_t, radius_in, scale_s, scale_t,
                  offset_s, offset_t, angle_deg, output ready);
endinterface

interface uvct_res_if #(parameter int W = uvct_pkg::WORD_BITS_DEF);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out_s;
    logic signed [W-1:0] out_t;
    logic signed [W-1:0] out_radius;
    modport source (output valid, out_s, out_t, out_radius, input ready);
    modport sink (input valid, out_s, out_t, out_radius, output ready);
endinterface

interface uvct_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [uvct_pkg::CFG_IDX_BITS-1:0]   index;
    logic [uvct_pkg::CFG_DATA_BITS-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/uvct_scale.sv =====
// Mirror, scale and offset of the coordinates and the scaled radius minimum.
module uvct_scale #(
    parameter int W = uvct_pkg::WORD_BITS_DEF,
    parameter int F = uvct_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                vld_in,
    input  logic                inv_s,
    input  logic                inv_t,
    input  logic signed [W-1:0] coord_s,
    input  logic signed [W-1:0] coord_t,
    input  logic signed [W-1:0] radius_in,
    input  logic signed [W-1:0] scale_s,
    input  logic signed [W-1:0] scale_t,
    input  logic signed [W-1:0] offset_s,
    input  logic signed [W-1:0] offset_t,
    output logic                vld_out,
    output logic signed [W-1:0] rs,
    output logic signed [W-1:0] rt,
    output logic signed [W-1:0] rr
);
    localparam logic signed [W-1:0]   MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]   MINW = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W+1:0]   ONE2 = (W+2)'(1) << F;

    function automatic logic signed [W-1:0] sat2(input logic signed [W+1:0] v);
        if (v > (W+2)'(MAXW)) begin
            return MAXW;
        end
        if (v < (W+2)'(MINW)) begin
            return MINW;
        end
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] mirror(input logic signed [W-1:0] x);
        logic signed [W+1:0] fr2;
        fr2 = signed'((W+2)'({x[F-1:0], 1'b0}));
        return sat2((W+2)'(x) + ONE2 - fr2);
    endfunction

    // Product shifted right by F with floor, saturated to the word.
    function automatic logic signed [W-1:0] msat(input logic signed [2*W-1:0] p);
        logic signed [2*W-1:0] sh;
        logic signed [2*W-1:0] top;
        sh  = p >>> F;
        top = sh >>> (W-1);
        if (top == '0 || top == '1) begin
            return sh[W-1:0];
        end
        return sh[2*W-1] ? MINW : MAXW;
    endfunction

    logic                  v1_reg, v2_reg, v3_reg;
    logic signed [W-1:0]   s1_reg, t1_reg, rad1_reg, ks1_reg, kt1_reg, os1_reg, ot1_reg;
    logic signed [2*W-1:0] ps2_reg, pt2_reg, pa2_reg, pb2_reg;
    logic signed [W-1:0]   os2_reg, ot2_reg;
    logic signed [W-1:0]   rs3_reg, rt3_reg, rr3_reg;
    logic signed [W-1:0]   ra_next, rb_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vld_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign ra_next = msat(pa2_reg);
    assign rb_next = msat(pb2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= inv_s ? mirror(coord_s) : coord_s;
            t1_reg   <= inv_t ? mirror(coord_t) : coord_t;
            rad1_reg <= radius_in;
            ks1_reg  <= scale_s;
            kt1_reg  <= scale_t;
            os1_reg  <= offset_s;
            ot1_reg  <= offset_t;

            ps2_reg <= (2*W)'(ks1_reg) * (2*W)'(s1_reg);
            pt2_reg <= (2*W)'(kt1_reg) * (2*W)'(t1_reg);
            pa2_reg <= (2*W)'(ks1_reg) * (2*W)'(rad1_reg);
            pb2_reg <= (2*W)'(kt1_reg) * (2*W)'(rad1_reg);
            os2_reg <= os1_reg;
            ot2_reg <= ot1_reg;

            rs3_reg <= sat2((W+2)'(msat(ps2_reg)) + (W+2)'(os2_reg));
            rt3_reg <= sat2((W+2)'(msat(pt2_reg)) + (W+2)'(ot2_reg));
            rr3_reg <= (ra_next < rb_next) ? ra_next : rb_next;
        end
    end

    assign vld_out = v3_reg;
    assign rs      = rs3_reg;
    assign rt      = rt3_reg;
    assign rr      = rr3_reg;
endmodule

// ===== hdl/uvct_angle.sv =====
// Degrees to a folded binary angle: reduction modulo 360 and exact divide by 360.
module uvct_angle #(
    parameter int W = uvct_pkg::WORD_BITS_DEF,
    parameter int F = uvct_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   vld_in,
    input  logic signed [W-1:0]                    angle_deg,
    output logic                                   vld_out,
    output logic                                   nz,
    output logic                                   flip,
    output logic signed [uvct_pkg::ANG_BITS-1:0]   z
);
    localparam int AB = uvct_pkg::ANG_BITS;
    localparam int HB = W - F - 3;
    // 360 degrees is 45 * 2^(F+3), so only the high part needs a residue mod 45.
    localparam int PW = (1 << (HB % 12)) % 45;
    localparam logic [5:0] P6 = 6'(PW);
    localparam logic signed [AB-1:0] QTR  = AB'(1) << 30;
    localparam logic signed [AB-1:0] HALF = AB'(1) << 31;

    logic [4:0]            vld_reg;
    logic [4:0]            nz_reg;
    logic [F+2:0]          l1_reg;
    logic                  sgn1_reg;
    logic [14:0]           fold1_reg;
    logic [63:0]           n2_reg, n3_reg;
    logic [14:0]           fold3_reg;
    logic [31:0]           z4_reg;
    logic signed [AB-1:0]  z5_reg;
    logic                  flip5_reg;

    logic [5:0]            um;
    logic [5:0]            m_next;
    logic [63:0]           nw;
    logic [5:0]            rem;
    logic [63:0]           diff;
    logic signed [AB-1:0]  zs;

    always_comb
    begin
        um = uvct_pkg::mod45_finish(fold1_reg);
        if (!sgn1_reg)
        begin
            m_next = um;
        end
        else if (um >= P6)
        begin
            m_next = um - P6;
        end
        else
        begin
            m_next = um + 6'd45 - P6;
        end
        nw   = 64'({m_next, l1_reg}) << (32 - F);
        rem  = uvct_pkg::mod45_finish(fold3_reg);
        diff = n3_reg - 64'(rem);
        zs   = AB'(signed'(z4_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nz_reg    <= {nz_reg[3:0], angle_deg != '0};
            l1_reg    <= angle_deg[F+2:0];
            sgn1_reg  <= angle_deg[W-1];
            fold1_reg <= uvct_pkg::mod45_fold(64'(angle_deg[W-1:F+3]));
            n2_reg    <= nw >> 3;
            fold3_reg <= uvct_pkg::mod45_fold(n2_reg);
            n3_reg    <= n2_reg;
            // The difference is an exact multiple of 45.
            z4_reg    <= diff[31:0] * uvct_pkg::INV45;
            if (zs > QTR)
            begin
                z5_reg    <= zs - HALF;
                flip5_reg <= 1'b1;
            end
            else if (zs < -QTR)
            begin
                z5_reg    <= zs + HALF;
                flip5_reg <= 1'b1;
            end
            else
            begin
                z5_reg    <= zs;
                flip5_reg <= 1'b0;
            end
        end
    end

    assign vld_out = vld_reg[4];
    assign nz      = nz_reg[4];
    assign flip    = flip5_reg;
    assign z       = z5_reg;
endmodule

// ===== hdl/uvct_cordic.sv =====
// Rotation-mode CORDIC, one micro-rotation per register stage.
module uvct_cordic #(
    parameter int STAGES = uvct_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  vld_in,
    input  logic                                  nz_in,
    input  logic                                  flip_in,
    input  logic signed [uvct_pkg::ANG_BITS-1:0]  z_in,
    output uvct_pkg::trig_t                       trig
);
    localparam int TB = uvct_pkg::TRIG_BITS;
    localparam int AB = uvct_pkg::ANG_BITS;

    logic [STAGES-1:0]     vld_reg;
    logic [STAGES-1:0]     nz_reg;
    logic [STAGES-1:0]     flip_reg;
    logic signed [TB-1:0]  x_reg [STAGES];
    logic signed [TB-1:0]  y_reg [STAGES];
    logic signed [AB-1:0]  z_reg [STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= STAGES'({vld_reg, vld_in});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nz_reg   <= STAGES'({nz_reg, nz_in});
            flip_reg <= STAGES'({flip_reg, flip_in});
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [TB-1:0] xi, yi;
        logic signed [AB-1:0] zi;
        logic signed [AB-1:0] at;
        if (i == 0) begin : g_first
            assign xi = TB'(uvct_pkg::GAIN_Q30);
            assign yi = '0;
            assign zi = z_in;
        end
        else begin : g_next
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
        end
        assign at = signed'(AB'(uvct_pkg::ATAN_TURN[i]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (zi >= 0)
                begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                    z_reg[i] <= zi - at;
                end
                else
                begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                    z_reg[i] <= zi + at;
                end
            end
        end
    end

    // The residual angle of the last stage is left unused.
    always_comb
    begin
        trig.vld = vld_reg[STAGES-1];
        trig.nz  = nz_reg[STAGES-1];
        trig.cs  = flip_reg[STAGES-1] ? -x_reg[STAGES-1] : x_reg[STAGES-1];
        trig.sn  = flip_reg[STAGES-1] ? -y_reg[STAGES-1] : y_reg[STAGES-1];
    end
endmodule

// ===== hdl/uvct_rotate.sv =====
// Rotation of the scaled point by the CORDIC cosine and sine, with saturation.
module uvct_rotate #(
    parameter int W = uvct_pkg::WORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  uvct_pkg::trig_t     trig,
    input  logic signed [W-1:0] rs,
    input  logic signed [W-1:0] rt,
    input  logic signed [W-1:0] rr,
    output logic                vld_out,
    output logic signed [W-1:0] out_s,
    output logic signed [W-1:0] out_t,
    output logic signed [W-1:0] out_radius
);
    localparam int TB = uvct_pkg::TRIG_BITS;
    localparam int PW = W + TB;
    localparam logic signed [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] sat1(input logic signed [W:0] v);
        if (v > (W+1)'(MAXW)) begin
            return MAXW;
        end
        if (v < (W+1)'(MINW)) begin
            return MINW;
        end
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] msat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] sh;
        logic signed [PW-1:0] top;
        sh  = p >>> uvct_pkg::TRIG_FRAC;
        top = sh >>> (W-1);
        if (top == '0 || top == '1) begin
            return sh[W-1:0];
        end
        return sh[PW-1] ? MINW : MAXW;
    endfunction

    logic                 v1_reg, v2_reg;
    logic                 nz1_reg;
    logic signed [PW-1:0] p_sc_reg, p_ts_reg, p_ss_reg, p_tc_reg;
    logic signed [W-1:0]  s1_reg, t1_reg, r1_reg;
    logic signed [W-1:0]  s2_reg, t2_reg, r2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= trig.vld;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_sc_reg <= PW'(rs) * PW'(trig.cs);
            p_ts_reg <= PW'(rt) * PW'(trig.sn);
            p_ss_reg <= PW'(rs) * PW'(trig.sn);
            p_tc_reg <= PW'(rt) * PW'(trig.cs);
            nz1_reg  <= trig.nz;
            s1_reg   <= rs;
            t1_reg   <= rt;
            r1_reg   <= rr;

            if (nz1_reg)
            begin
                s2_reg <= sat1((W+1)'(msat(p_sc_reg)) - (W+1)'(msat(p_ts_reg)));
                t2_reg <= sat1((W+1)'(msat(p_ss_reg)) + (W+1)'(msat(p_tc_reg)));
            end
            else
            begin
                s2_reg <= s1_reg;
                t2_reg <= t1_reg;
            end
            r2_reg <= r1_reg;
        end
    end

    assign vld_out    = v2_reg;
    assign out_s      = s2_reg;
    assign out_t      = t2_reg;
    assign out_radius = r2_reg;
endmodule

// ===== hdl/uv_coordinate_transform.sv =====
// Top level of the texture coordinate transform pipeline.
// The block takes one point item per cycle while it is not halted, and returns
// one result per item in order: five stages turn degrees into a folded binary
// angle, one stage per CORDIC micro-rotation follows, and two stages multiply
// and saturate the rotation, while the mirror, scale and offset path runs
// alongside and waits in a delay line. The whole pipeline advances together and
// halts only while a finished result is held on the output and not taken, so
// pt.ready is low exactly then. Configuration writes are taken in any cycle and
// apply to items accepted after them.
`include "uv_coordinate_transform_assert.svh"

module uv_coordinate_transform #(
    parameter int WORD_BITS     = uvct_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS     = uvct_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = uvct_pkg::CORDIC_STAGES_DEF
) (
    input logic                 clk,
    input logic                 rst_n,
    uvct_pt_if.sink             pt,
    uvct_res_if.source          res,
    uvct_cfg_if.sink            cfg
);
    localparam int W   = WORD_BITS;
    localparam int DLY = CORDIC_STAGES + 2;

    logic                en;
    logic                invs_reg, invt_reg;
    logic                sc_vld;
    logic signed [W-1:0] sc_s, sc_t, sc_r;
    logic                an_vld, an_nz, an_flip;
    logic signed [uvct_pkg::ANG_BITS-1:0] an_z;
    uvct_pkg::trig_t     trig;
    logic                rot_vld;

    logic [DLY-1:0]      dv_reg;
    logic signed [W-1:0] ds_reg [DLY];
    logic signed [W-1:0] dt_reg [DLY];
    logic signed [W-1:0] dr_reg [DLY];

    assign en        = !rot_vld || res.ready;
    assign pt.ready  = en;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invs_reg <= 1'b0;
            invt_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (uvct_pkg::cfg_reg_t'(cfg.index))
                uvct_pkg::CFG_INVERT_S: invs_reg <= cfg.data[0];
                uvct_pkg::CFG_INVERT_T: invt_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    uvct_scale #(.W(W), .F(FRAC_BITS)) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vld_in    (pt.valid),
        .inv_s     (invs_reg),
        .inv_t     (invt_reg),
        .coord_s   (pt.coord_s),
        .coord_t   (pt.coord_t),
        .radius_in (pt.radius_in),
        .scale_s   (pt.scale_s),
        .scale_t   (pt.scale_t),
        .offset_s  (pt.offset_s),
        .offset_t  (pt.offset_t),
        .vld_out   (sc_vld),
        .rs        (sc_s),
        .rt        (sc_t),
        .rr        (sc_r)
    );

    uvct_angle #(.W(W), .F(FRAC_BITS)) u_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vld_in    (pt.valid),
        .angle_deg (pt.angle_deg),
        .vld_out   (an_vld),
        .nz        (an_nz),
        .flip      (an_flip),
        .z         (an_z)
    );

    uvct_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (an_vld),
        .nz_in   (an_nz),
        .flip_in (an_flip),
        .z_in    (an_z),
        .trig    (trig)
    );

    // The scaled point waits here until its sine and cosine are ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= '0;
        end
        else if (en)
        begin
            dv_reg <= DLY'({dv_reg, sc_vld});
        end
    end

    for (genvar i = 0; i < DLY; i++) begin : g_dly
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ds_reg[i] <= (i == 0) ? sc_s : ds_reg[(i == 0) ? 0 : i-1];
                dt_reg[i] <= (i == 0) ? sc_t : dt_reg[(i == 0) ? 0 : i-1];
                dr_reg[i] <= (i == 0) ? sc_r : dr_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    uvct_rotate #(.W(W)) u_rotate (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .trig       (trig),
        .rs         (ds_reg[DLY-1]),
        .rt         (dt_reg[DLY-1]),
        .rr         (dr_reg[DLY-1]),
        .vld_out    (rot_vld),
        .out_s      (res.out_s),
        .out_t      (res.out_t),
        .out_radius (res.out_radius)
    );

    assign res.valid = rot_vld;

    // The delayed point and its trigonometry must belong to the same item.
    `UVCT_ASSERT_NOW(a_path_align, 1'b1, dv_reg[DLY-1] == trig.vld)
    // An empty output stage never holds off new items.
    `UVCT_ASSERT_NOW(a_ready_when_empty, !rot_vld, pt.ready)
    // A write to invert_s leaves invert_t alone.
    `UVCT_ASSERT_NEXT(a_cfg_s_only, cfg.valid && cfg.index == uvct_pkg::CFG_INVERT_S, $stable(invt_reg))
endmodule

// ===== tb/sv/uv_coordinate_transform_tb.sv =====
// Testbench for the texture coordinate transform: directed and random point items.
module uv_coordinate_transform_tb;

    typedef struct packed {
        logic signed [31:0] cs, ct, rad, ks, kt, os, ot, ang;
    } point_t;

    typedef struct packed {
        logic signed [31:0] s, t, r;
    } coord_res_t;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam int LATENCY = uvct_pkg::CORDIC_STAGES_DEF + 7;
    localparam int CYCLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #10 clk = ~clk;

    uvct_pt_if  pt ();
    uvct_res_if res ();
    uvct_cfg_if cfg ();

    uv_coordinate_transform u_dut (.clk(clk), .rst_n(rst_n), .pt(pt), .res(res), .cfg(cfg));

    bit mirror_s_q, mirror_t_q;
    coord_res_t pending_coords[$];
    int mismatches;
    int cycles;
    int hold_cnt = 0;
    bit stall_enable = 1'b1;

    function automatic longint clamp32(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    // Product floored and saturated; 128 bits hold any 64x64 product exactly.
    function automatic longint mul_sh(longint a, longint b, int sh);
        logic signed [127:0] p;
        p = (128'(signed'(a)) * 128'(signed'(b))) >>> sh;
        if (p > 128'(signed'(WMAX))) return WMAX;
        if (p < 128'(signed'(WMIN))) return WMIN;
        return longint'(p);
    endfunction

    function automatic longint fold_mirror(longint x);
        longint fr;
        fr = x & 64'hFFFF;
        return clamp32(x + 65536 - 2 * fr);
    endfunction

    function automatic longint asr_l(longint v, int s);
        return v >>> s;
    endfunction

    task automatic trig_of(input longint deg, output longint sn, output longint cs);
        longint full, r, z, x, y, nx;
        bit flip;
        full = 64'd360 << 16;
        r = deg % full;
        if (r < 0) r += full;
        z = longint'((64'(r) << 16) / 360);
        if (z >= (64'sd1 << 31)) z -= (64'sd1 << 32);
        flip = 1'b0;
        if (z > (64'sd1 << 30)) begin z -= (64'sd1 << 31); flip = 1'b1; end
        else if (z < -(64'sd1 << 30)) begin z += (64'sd1 << 31); flip = 1'b1; end
        x = longint'(uvct_pkg::GAIN_Q30);
        y = 0;
        for (int i = 0; i < uvct_pkg::CORDIC_STAGES_DEF; i++)
        begin
            if (z >= 0)
            begin
                nx = x - asr_l(y, i);
                y = y + asr_l(x, i);
                z -= longint'(uvct_pkg::ATAN_TURN[i]);
            end
            else
            begin
                nx = x + asr_l(y, i);
                y = y - asr_l(x, i);
                z += longint'(uvct_pkg::ATAN_TURN[i]);
            end
            x = nx;
        end
        if (flip) begin x = -x; y = -y; end
        cs = x;
        sn = y;
    endtask

    task automatic transform_point(input point_t p, output coord_res_t r);
        longint s, t, rs, rt, ra, rb, sn, cs, nx, ny;
        s = p.cs;
        t = p.ct;
        if (mirror_s_q) s = fold_mirror(s);
        if (mirror_t_q) t = fold_mirror(t);
        rs = clamp32(mul_sh(p.ks, s, 16) + p.os);
        rt = clamp32(mul_sh(p.kt, t, 16) + p.ot);
        ra = mul_sh(p.ks, p.rad, 16);
        rb = mul_sh(p.kt, p.rad, 16);
        if (p.ang != 0)
        begin
            trig_of(p.ang, sn, cs);
            nx = clamp32(mul_sh(rs, cs, 30) - mul_sh(rt, sn, 30));
            ny = clamp32(mul_sh(rs, sn, 30) + mul_sh(rt, cs, 30));
            rs = nx;
            rt = ny;
        end
        r.s = rs[31:0];
        r.t = rt[31:0];
        r.r = (ra < rb) ? ra[31:0] : rb[31:0];
    endtask

    task automatic wait_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    task automatic idle_input();
        pt.valid <= 1'b0;
    endtask

    // Valid stays high into the next item when no gap is drawn.
    task automatic send_point(point_t p);
        coord_res_t r;
        int n;
        n = $urandom_range(0, 5) * stall_enable * ($urandom_range(0, 3) != 0);
        if (n != 0)
        begin
            pt.valid <= 1'b0;
            wait_cycles(n);
        end
        pt.valid <= 1'b1;
        {pt.coord_s, pt.coord_t, pt.radius_in, pt.scale_s, pt.scale_t,
         pt.offset_s, pt.offset_t, pt.angle_deg} <= p;
        do @(posedge clk); while (!pt.ready);
        transform_point(p, r);
        pending_coords.push_back(r);
    endtask

    task automatic drain();
        idle_input();
        while (pending_coords.size() != 0) @(posedge clk);
        wait_cycles(LATENCY);
    endtask

    task automatic write_reg(uvct_pkg::cfg_reg_t idx, logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == uvct_pkg::CFG_INVERT_S) mirror_s_q = value[0];
        else mirror_t_q = value[0];
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
            3: return 32'(signed'($urandom_range(0, 400 << 16)) - (200 << 16));
            default: return $urandom;
        endcase
    endfunction

    function automatic point_t rand_point();
        point_t p;
        p.cs = rand_word();
        p.ct = rand_word();
        p.rad = rand_word();
        p.ks = rand_word();
        p.kt = rand_word();
        p.os = rand_word();
        p.ot = rand_word();
        p.ang = ($urandom_range(0, 7) == 0) ? 32'sd0 : rand_word();
        return p;
    endfunction

    task automatic test_directed();
        point_t p;
        int angles[6] = '{0, 90 << 16, 180 << 16, -90 << 16, 360 << 16, 45 << 16};
        foreach (angles[i])
        begin
            p = '{32'sh18000, 32'sh2C000, 32'sh10000, 32'sh20000, 32'sh8000,
                  32'sh1000, -32'sh1000, angles[i]};
            send_point(p);
        end
        // Word extremes, including mirroring at the top integer of the range.
        p = '{32'h7FFFFFFF, 32'h7FFF0000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
              32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
        send_point(p);
        p = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
              32'h80000000, 32'h7FFFFFFF, 32'h80000000};
        send_point(p);
        p = '{32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0,
              32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF};
        send_point(p);
        // Large scale whose product saturates before the offset pulls it back.
        p = '{32'sh01000000, 32'sh01000000, 32'sh1, 32'sh01000000, 32'sh01000000,
              32'h80000000, 32'h80000000, 32'sh0};
        send_point(p);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            send_point(rand_point());
            // One hold-off until the pipeline has emptied.
            if (i == n / 2)
            begin
                idle_input();
                while (pending_coords.size() != 0) @(posedge clk);
            end
        end
    endtask

    // The result side waits a drawn number of cycles after each item it takes.
    always @(posedge clk)
    begin
        int hold;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                hold = int'($urandom_range(0, 5)) * int'(stall_enable);
                hold_cnt <= hold;
                res.ready <= (hold == 0);
            end
            else if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                res.ready <= (hold_cnt == 1);
            end
            else
                res.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        coord_res_t e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_coords.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("result item with nothing expected");
            end
            else
            begin
                e = pending_coords.pop_front();
                if (e.s !== res.out_s || e.t !== res.out_t || e.r !== res.out_radius)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected s=%h t=%h r=%h got s=%h t=%h r=%h",
                                 e.s, e.t, e.r, res.out_s, res.out_t, res.out_radius);
                end
            end
        end
    end

    initial
    begin
        pt.valid = 1'b0;
        {pt.coord_s, pt.coord_t, pt.radius_in, pt.scale_s, pt.scale_t,
         pt.offset_s, pt.offset_t, pt.angle_deg} = '0;
        res.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = uvct_pkg::CFG_INVERT_S;
        cfg.data = '0;
        mismatches = 0;
        cycles = 0;
        mirror_s_q = 1'b0;
        mirror_t_q = 1'b1;
        wait_cycles(9);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        drain();
        write_reg(uvct_pkg::CFG_INVERT_S, 32'hFFFFFFFF);
        write_reg(uvct_pkg::CFG_INVERT_T, 32'h0);
        test_directed();
        test_random(150);
        drain();
        write_reg(uvct_pkg::CFG_INVERT_S, 32'h1);
        write_reg(uvct_pkg::CFG_INVERT_T, 32'hFFFFFFFE);
        write_reg(uvct_pkg::CFG_INVERT_T, 32'h1);
        test_random(150);
        drain();
        stall_enable = 1'b0;
        write_reg(uvct_pkg::CFG_INVERT_S, 32'h0);
        test_random(100);
        drain();
        stall_enable = 1'b1;
        write_reg(uvct_pkg::CFG_INVERT_T, 32'h0);
        test_random(100);
        drain();
        if (mismatches == 0 && pending_coords.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
